>>> rtl/dna_kmer_histogram_assert.svh
// Assertion macros for the k-mer histogram.
`ifndef DNA_KMER_HISTOGRAM_ASSERT_SVH
`define DNA_KMER_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DKH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define DKH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dkh_pkg.sv
package dkh_pkg;

   localparam int K_MAX       = 8;
   localparam int WIN_BITS    = 2 * K_MAX;
   localparam int COUNT_BITS  = 32;
   localparam int OUT_BITS    = 32;
   localparam int TABLE_DEPTH = 1 << WIN_BITS;
   localparam int RUN_BITS    = 4;
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] REQ_BASE = 2'd0;
   localparam logic [1:0] REQ_EOS  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic OP_INC  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [WIN_BITS-1:0] index;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } op_beat_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> rtl/dkh_front.sv
module dkh_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [3:0]                     csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic [2:0]                     req_base,
   input  logic [15:0]                    req_query_index,
   input  logic                           clearing,
   input  dkh_pkg::q_status_type          q_status,
   output dkh_pkg::op_beat_type           push
);
   import dkh_pkg::*;

   logic [3:0]          k_len_ff, k_len_in;
   logic [WIN_BITS-1:0] window_ff, window_in;
   logic [RUN_BITS-1:0] run_ff, run_in;
   logic [RUN_BITS-1:0] k_eff;
   logic [RUN_BITS-1:0] run_next;
   logic [WIN_BITS-1:0] window_next;
   logic [WIN_BITS-1:0] kmask;
   logic                accept;

   assign req_ready = !clearing && !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (k_len_ff == 4'd0) begin
         k_eff = RUN_BITS'(1);
      end else if (k_len_ff > RUN_BITS'(K_MAX)) begin
         k_eff = RUN_BITS'(K_MAX);
      end else begin
         k_eff = k_len_ff;
      end
   end

   assign window_next = {window_ff[WIN_BITS-3:0], req_base[1:0]};
   assign run_next    = (run_ff < RUN_BITS'(K_MAX)) ? run_ff + RUN_BITS'(1) : run_ff;
   assign kmask       = ~({WIN_BITS{1'b1}} << {k_eff, 1'b0});
   assign k_len_in    = csr_write_enable ? csr_write_data : k_len_ff;

   always_comb begin
      window_in  = window_ff;
      run_in     = run_ff;
      push       = '0;
      if (accept) begin
         unique case (req_type)
            REQ_BASE: begin
               if (req_base[2]) begin
                  window_in = '0;
                  run_in    = '0;
               end else begin
                  window_in = window_next;
                  run_in    = run_next;
                  if (run_next >= k_eff) begin
                     push.valid    = 1'b1;
                     push.op.kind  = OP_INC;
                     push.op.index = window_next & kmask;
                  end
               end
            end
            REQ_EOS: begin
               window_in = '0;
               run_in    = '0;
            end
            REQ_READ: begin
               push.valid    = 1'b1;
               push.op.kind  = OP_READ;
               push.op.index = req_query_index[WIN_BITS-1:0];
            end
            default: begin
               // drop unused request code
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_len_ff  <= 4'd3;
         window_ff <= '0;
         run_ff    <= '0;
      end else begin
         k_len_ff  <= k_len_in;
         window_ff <= window_in;
         run_ff    <= run_in;
      end
   end

endmodule

>>> rtl/dkh_queue.sv
module dkh_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  dkh_pkg::op_beat_type  push,
   input  logic                  pop,
   output dkh_pkg::op_type       head,
   output dkh_pkg::q_status_type status
);
   import dkh_pkg::*;

   op_type                entries_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;

   assign head         = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == Q_CNT_BITS'(Q_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + Q_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + Q_CNT_BITS'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - Q_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/dkh_back.sv
module dkh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dkh_pkg::op_type       head,
   input  dkh_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  clearing,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_kmer_count
);
   import dkh_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [COUNT_BITS-1:0] count_mem [TABLE_DEPTH];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [1:0]            state_ff, state_in;
   logic [WIN_BITS-1:0]   clr_ptr_ff, clr_ptr_in;
   op_type                op_ff, op_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic [WIN_BITS-1:0]   rd_addr;
   logic [WIN_BITS-1:0]   wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic                  wr_en;
   logic [COUNT_BITS-1:0] inc_value;

   assign clearing       = (state_ff == ST_CLEAR);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kmer_count = rsp_data_ff;
   assign rd_addr        = (state_ff == ST_IDLE) ? head.index : op_ff.index;
   assign inc_value      = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + COUNT_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      op_in        = op_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = op_ff.index;
      wr_data      = inc_value;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_ptr_ff;
            wr_data    = '0;
            clr_ptr_in = clr_ptr_ff + WIN_BITS'(1);
            if (clr_ptr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               op_in    = head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff.kind == OP_INC) begin
               wr_en    = 1'b1;
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OUT_BITS'(rd_data_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= count_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/dna_kmer_histogram.sv
// DNA k-mer histogram. Bases (A, C, G, T as 0 to 3, anything else as N) stream in on the
// req_ channel; every window of k_len unbroken bases (k_len 0 counts as 1, above 8 as 8)
// bumps a saturating 32-bit count in a 65536-entry table, an N or an end-of-sequence beat
// restarts the window, and a read beat returns one count on the rsp_ channel. After reset
// the table is zeroed by a clearing pass, during which req_ready stays low (csr_ writes are
// still taken). The front takes one beat per cycle, while the queue is not full and no clear
// pass runs, into a four-entry queue; the back works on one table operation at a time
// (registered memory read, then update or response) and pops the next only when it is
// through, while beats that touch no table entry never enter the queue.
module dna_kmer_histogram (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [2:0]  req_base,
   input  logic [15:0] req_query_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_kmer_count
);
   import dkh_pkg::*;

`include "dna_kmer_histogram_assert.svh"

   op_beat_type  push;
   op_type       head;
   q_status_type q_status;
   logic         pop;
   logic         clearing;

   dkh_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_base         (req_base),
      .req_query_index  (req_query_index),
      .clearing         (clearing),
      .q_status         (q_status),
      .push             (push)
   );

   dkh_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   dkh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kmer_count (rsp_kmer_count)
   );

   `DKH_ASSERT_NOW(a_no_push_full, q_status.full, !push.valid, "push into full queue")
   `DKH_ASSERT_NOW(a_no_pop_empty, pop, !q_status.empty, "pop from empty queue")
   `DKH_ASSERT_NOW(a_no_rsp_clear, clearing, !rsp_valid && !push.valid, "activity during clear")
   `DKH_ASSERT_NEXT(a_pop_leaves, pop && !push.valid, !q_status.full, "queue full after pop")

endmodule
